@@ design/rotation_matrix_to_euler_unit_assert.svh @@
// assertion helpers for the rotation matrix to euler unit
`ifndef ROTATION_MATRIX_TO_EULER_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_EULER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RM2E_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rm2e implication check failed");

// antecedent implies consequent in the next cycle
`define RM2E_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rm2e next-cycle check failed");

// condition never holds
`define RM2E_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rm2e forbidden condition seen");

`endif

@@ design/rm2e_pkg.sv @@
package rm2e_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int MAX_STAGES = 24;

  localparam logic signed [25:0] HALF_TURN = 26'sd11796480;
  localparam logic signed [16:0] ANG_MAX = 17'sd23040;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic signed [25:0] ATAN_TAB [MAX_STAGES] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379, 26'sd117304,
    26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
    26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
    26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0
  };

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } rm2e_mat_t;

  typedef struct packed {
    logic signed [16:0] y;
    logic signed [16:0] x;
  } rm2e_vec_t;

  typedef struct packed {
    rm2e_vec_t vx;
    rm2e_vec_t vy;
    rm2e_vec_t vz;
    logic      singular;
  } rm2e_job_t;

  typedef struct packed {
    logic push;
    logic stall;
  } rm2e_front_stat_t;

  function automatic logic signed [16:0] neg17(input logic signed [15:0] a);
    logic signed [16:0] t;
    t = a;
    return -t;
  endfunction

  function automatic logic signed [16:0] ext17(input logic signed [15:0] a);
    logic signed [16:0] t;
    t = a;
    return t;
  endfunction

  // round half up to 1/128 degree, then saturate
  function automatic logic signed [15:0] to_units(input logic signed [25:0] z);
    logic signed [25:0] s;
    logic signed [16:0] q;
    s = z + 26'sd256;
    q = 17'(s >>> 9);
    if (q > ANG_MAX) q = ANG_MAX;
    if (q < -ANG_MAX) q = -ANG_MAX;
    return q[15:0];
  endfunction

endpackage

@@ design/rm2e_if.sv @@
interface rm2e_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] r00;
  logic signed [15:0] r10;
  logic signed [15:0] r11;
  logic signed [15:0] r12;
  logic signed [15:0] r20;
  logic signed [15:0] r21;
  logic signed [15:0] r22;
  modport source (output valid, r00, r10, r11, r12, r20, r21, r22, input ready);
  modport sink (input valid, r00, r10, r11, r12, r20, r21, r22, output ready);
endinterface

interface rm2e_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;
  logic               is_singular;
  modport source (output valid, angle_x, angle_y, angle_z, is_singular, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, is_singular, output ready);
endinterface

@@ design/rm2e_front.sv @@
module rm2e_front import rm2e_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  rm2e_in_if.sink          matrix,
  input  logic [10:0]      threshold,
  output rm2e_job_t        job,
  output logic             job_valid,
  input  logic             job_full,
  output rm2e_front_stat_t status
);

  localparam int SQ_STEPS = 16;

  logic en;
  rm2e_mat_t in_m;
  logic signed [31:0] p0, p1;

  logic      a_vld;
  rm2e_mat_t a_m;
  logic [30:0] a_sq0, a_sq1;

  logic      sq_vld [SQ_STEPS+1];
  rm2e_mat_t sq_m   [SQ_STEPS+1];
  logic [31:0] sq_n   [SQ_STEPS+1];
  logic [31:0] sq_res [SQ_STEPS+1];

  logic      c_vld;
  rm2e_job_t c_job;
  logic [15:0] sy;
  logic      sing;

  assign en = !(c_vld && job_full);
  assign matrix.ready = en;

  assign in_m = '{r00: matrix.r00, r10: matrix.r10, r11: matrix.r11, r12: matrix.r12,
                  r20: matrix.r20, r21: matrix.r21, r22: matrix.r22};
  assign p0 = matrix.r00 * matrix.r00;
  assign p1 = matrix.r10 * matrix.r10;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= matrix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_m   <= in_m;
      a_sq0 <= p0[30:0];
      a_sq1 <= p1[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_m[0]   <= a_m;
      sq_n[0]   <= {1'b0, a_sq0} + {1'b0, a_sq1};
      sq_res[0] <= '0;
    end
  end

  // bit-pair square root, one result bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [31:0] BIT = 32'd1 << (30 - 2 * k);
    logic [31:0] trial;
    assign trial = sq_res[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_m[k+1] <= sq_m[k];
        if (sq_n[k] >= trial) begin
          sq_n[k+1]   <= sq_n[k] - trial;
          sq_res[k+1] <= (sq_res[k] >> 1) + BIT;
        end else begin
          sq_n[k+1]   <= sq_n[k];
          sq_res[k+1] <= sq_res[k] >> 1;
        end
      end
    end
  end

  assign sy   = sq_res[SQ_STEPS][15:0];
  assign sing = sy < {5'b0, threshold};

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= sq_vld[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_job.singular <= sing;
      c_job.vy.y     <= neg17(sq_m[SQ_STEPS].r20);
      c_job.vy.x     <= {1'b0, sy};
      c_job.vz.y     <= ext17(sq_m[SQ_STEPS].r10);
      c_job.vz.x     <= ext17(sq_m[SQ_STEPS].r00);
      if (sing) begin
        c_job.vx.y <= neg17(sq_m[SQ_STEPS].r12);
        c_job.vx.x <= ext17(sq_m[SQ_STEPS].r11);
      end else begin
        c_job.vx.y <= ext17(sq_m[SQ_STEPS].r21);
        c_job.vx.x <= ext17(sq_m[SQ_STEPS].r22);
      end
    end
  end

  assign job          = c_job;
  assign job_valid    = c_vld;
  assign status.push  = c_vld && !job_full;
  assign status.stall = c_vld && job_full;

endmodule

@@ design/rm2e_fifo.sv @@
module rm2e_fifo import rm2e_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  rm2e_job_t din,
  output logic      full,
  input  logic      rd_en,
  output rm2e_job_t dout,
  output logic      dout_valid
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  rm2e_job_t mem [FIFO_DEPTH];
  logic [PW-1:0] wp, rp;
  logic [CW-1:0] cnt;
  logic load, take_mem, bypass, wr;

  assign load     = !dout_valid || rd_en;
  assign take_mem = load && (cnt != '0);
  assign bypass   = load && (cnt == '0) && push;
  assign wr       = push && !bypass;
  assign full     = cnt == CW'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      rp         <= '0;
      cnt        <= '0;
      dout_valid <= 1'b0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (take_mem) rp <= rp + 1'b1;
      cnt <= cnt + CW'(wr) - CW'(take_mem);
      if (load) dout_valid <= take_mem || bypass;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= din;
    if (take_mem) begin
      dout <= mem[rp];
    end else if (bypass) begin
      dout <= din;
    end
  end

endmodule

@@ design/rm2e_cordic.sv @@
module rm2e_cordic import rm2e_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic                clk,
  input  logic                en,
  input  rm2e_vec_t           vin,
  output logic signed [25:0]  angle
);

  logic signed [35:0] x [STAGES+1];
  logic signed [35:0] y [STAGES+1];
  logic signed [25:0] z [STAGES+1];
  logic               byp [STAGES+1];

  logic signed [35:0] px, py;
  logic signed [25:0] pz;
  logic               pb;

  // quadrant fold; a zero y needs no rotation at all
  always_comb begin
    pb = 1'b0;
    pz = '0;
    px = 36'(vin.x);
    py = 36'(vin.y);
    if (vin.y == '0) begin
      pb = 1'b1;
      pz = (vin.x < 0) ? HALF_TURN : 26'sd0;
      px = '0;
      py = '0;
    end else if (vin.x < 0) begin
      px = -px;
      py = -py;
      pz = (vin.y > 0) ? HALF_TURN : -HALF_TURN;
    end
    px = px <<< 16;
    py = py <<< 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]   <= px;
      y[0]   <= py;
      z[0]   <= pz;
      byp[0] <= pb;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [35:0] xs, ys;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        byp[i+1] <= byp[i];
        if (byp[i]) begin
          x[i+1] <= x[i];
          y[i+1] <= y[i];
          z[i+1] <= z[i];
        end else if (y[i] >= 0) begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + ATAN_TAB[i];
        end else begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - ATAN_TAB[i];
        end
      end
    end
  end

  assign angle = z[STAGES];

endmodule

@@ design/rm2e_back.sv @@
module rm2e_back import rm2e_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  rm2e_job_t job,
  input  logic      job_valid,
  output logic      job_rd,
  rm2e_out_if.source angles
);

  logic en;
  logic vld  [STAGES+1];
  logic sing [STAGES+1];
  logic signed [25:0] zx, zy, zz;

  logic               o_vld;
  logic signed [15:0] o_x, o_y, o_z;
  logic               o_s;

  assign en     = !o_vld || angles.ready;
  assign job_rd = en;

  rm2e_cordic #(.STAGES(STAGES)) u_lane_x (.clk(clk), .en(en), .vin(job.vx), .angle(zx));
  rm2e_cordic #(.STAGES(STAGES)) u_lane_y (.clk(clk), .en(en), .vin(job.vy), .angle(zy));
  rm2e_cordic #(.STAGES(STAGES)) u_lane_z (.clk(clk), .en(en), .vin(job.vz), .angle(zz));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) sing[0] <= job.singular;
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) sing[k+1] <= sing[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= vld[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_x <= to_units(zx);
      o_y <= to_units(zy);
      o_z <= sing[STAGES] ? 16'sd0 : to_units(zz);
      o_s <= sing[STAGES];
    end
  end

  assign angles.valid       = o_vld;
  assign angles.angle_x     = o_x;
  assign angles.angle_y     = o_y;
  assign angles.angle_z     = o_z;
  assign angles.is_singular = o_s;

endmodule

@@ design/rotation_matrix_to_euler_unit.sv @@
// throughput: one matrix per cycle unless the queue is full, set by the fully pipelined root and CORDIC lanes
// a 4-entry queue between root front end and CORDIC back end absorbs output stalls
// reset (rst, synchronous): all valid flags and queue pointers clear, threshold returns to 1
// datapath registers are not reset
`include "rotation_matrix_to_euler_unit_assert.svh"

module rotation_matrix_to_euler_unit import rm2e_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  rm2e_in_if.sink     matrix,
  rm2e_out_if.source  angles
);

  // no more than the table length of stages is ever run
  localparam int LANE_STAGES = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;

  logic [10:0]      threshold;
  rm2e_job_t        f_job, q_job;
  logic             f_valid, q_full, q_valid, q_rd;
  rm2e_front_stat_t f_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 11'd1;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  rm2e_front u_front (
    .clk(clk), .rst(rst), .matrix(matrix), .threshold(threshold),
    .job(f_job), .job_valid(f_valid), .job_full(q_full), .status(f_stat)
  );

  rm2e_fifo u_queue (
    .clk(clk), .rst(rst), .push(f_stat.push), .din(f_job), .full(q_full),
    .rd_en(q_rd), .dout(q_job), .dout_valid(q_valid)
  );

  rm2e_back #(.STAGES(LANE_STAGES)) u_back (
    .clk(clk), .rst(rst), .job(q_job), .job_valid(q_valid), .job_rd(q_rd),
    .angles(angles)
  );

  `RM2E_ASSERT_NEVER(a_queue_no_overflow, f_stat.push && q_full)
  `RM2E_ASSERT_NEXT(a_stall_holds_job, f_stat.stall, f_valid)
  `RM2E_ASSERT_IMP(a_singular_zero_z, angles.valid && angles.is_singular, angles.angle_z == 16'sd0)
  `RM2E_ASSERT_IMP(a_y_in_range, angles.valid, (17'(angles.angle_y) <= ANG_MAX) && (17'(angles.angle_y) >= -ANG_MAX))

endmodule

@@ test/rm2e_checker.sv @@
`timescale 1ns / 100ps

module rm2e_checker import rm2e_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  rm2e_in_if          matrix,
  rm2e_out_if         angles,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic               is_singular;
  } euler_t;

  euler_t      euler_q[$];
  logic [10:0] threshold;

  function automatic longint root_floor(longint n);
    longint res, b;
    res = 0;
    b = longint'(1) << 30;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // vectoring cordic, degrees with 16 fraction bits
  function automatic longint vector_angle(longint y, longint x);
    longint z, xs, ys;
    int     n;
    z = 0;
    n = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
    if (y == 0) return (x < 0) ? longint'(HALF_TURN) : 0;
    if (x < 0) begin
      z = (y > 0) ? longint'(HALF_TURN) : -longint'(HALF_TURN);
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TAB[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic logic signed [15:0] deg128(longint z);
    longint q;
    q = (z + 256) >>> 9;
    if (q > 23040) q = 23040;
    if (q < -23040) q = -23040;
    return 16'(q);
  endfunction

  function automatic euler_t predict_euler(rm2e_mat_t m);
    euler_t e;
    longint sy;
    sy = root_floor(longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10);
    e.is_singular = sy < threshold;
    if (!e.is_singular) begin
      e.angle_x = deg128(vector_angle(m.r21, m.r22));
      e.angle_z = deg128(vector_angle(m.r10, m.r00));
    end else begin
      e.angle_x = deg128(vector_angle(-longint'(m.r12), m.r11));
      e.angle_z = '0;
    end
    e.angle_y = deg128(vector_angle(-longint'(m.r20), sy));
    return e;
  endfunction

  always @(posedge clk) begin
    rm2e_mat_t m;
    euler_t    exp_e, got;
    if (rst) begin
      threshold <= 11'd1;
    end else begin
      if (cfg_wr_en) threshold <= cfg_wr_data;
      if (matrix.valid && matrix.ready) begin
        m = '{matrix.r00, matrix.r10, matrix.r11, matrix.r12,
              matrix.r20, matrix.r21, matrix.r22};
        euler_q = {euler_q, predict_euler(m)};
      end
      if (angles.valid && angles.ready) begin
        got = '{angles.angle_x, angles.angle_y, angles.angle_z, angles.is_singular};
        if (euler_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, actual %p", $time, got);
        end else begin
          exp_e = euler_q.pop_front();
          if (got.angle_x !== exp_e.angle_x) begin
            errors++;
            $display("%0t: angle_x expected %0d actual %0d", $time, exp_e.angle_x, got.angle_x);
          end
          if (got.angle_y !== exp_e.angle_y) begin
            errors++;
            $display("%0t: angle_y expected %0d actual %0d", $time, exp_e.angle_y, got.angle_y);
          end
          if (got.angle_z !== exp_e.angle_z) begin
            errors++;
            $display("%0t: angle_z expected %0d actual %0d", $time, exp_e.angle_z, got.angle_z);
          end
          if (got.is_singular !== exp_e.is_singular) begin
            errors++;
            $display("%0t: is_singular expected %0b actual %0b", $time,
                     exp_e.is_singular, got.is_singular);
          end
        end
      end
    end
    pending = euler_q.size();
  end

  initial errors = 0;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench import rm2e_pkg::*; ();

  localparam int PHASE_ITEMS = 210;
  localparam int DRAIN_CYCLES = 60;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;
  int          errors;
  int          pending;
  bit          idle_on;
  bit          long_hold;

  rm2e_in_if  matrix_ch ();
  rm2e_out_if angle_ch ();

  rotation_matrix_to_euler_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .matrix      (matrix_ch),
    .angles      (angle_ch)
  );

  rm2e_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .matrix      (matrix_ch),
    .angles      (angle_ch),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("[rotation_matrix_to_euler_unit] ERROR");
    $finish;
  end

  // output side: random stall bursts and one long hold-off
  initial begin
    int n;
    angle_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        angle_ch.ready = 1'b0;
        for (int i = 0; i < 200; i++) @(negedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        angle_ch.ready = 1'b0;
        n = $urandom_range(1, 4);
        for (int i = 1; i < n; i++) @(negedge clk);
      end else begin
        angle_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_mat(rm2e_mat_t m);
    int n;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      matrix_ch.valid = 1'b0;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) @(negedge clk);
    end
    {matrix_ch.r00, matrix_ch.r10, matrix_ch.r11, matrix_ch.r12,
     matrix_ch.r20, matrix_ch.r21, matrix_ch.r22} = m;
    matrix_ch.valid = 1'b1;
    do @(posedge clk); while (!matrix_ch.ready);
  endtask

  task automatic set_threshold(logic [10:0] v);
    @(negedge clk);
    matrix_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic signed [15:0] q14(real v);
    int t;
    t = $rtoi(v * 16384.0 + ((v < 0) ? -0.5 : 0.5));
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return 16'(t);
  endfunction

  // z-y-x rotation with a little noise on r00 and r10
  function automatic rm2e_mat_t euler_mat(real ax, real ay, real az, int noise);
    rm2e_mat_t m;
    real cx, sx, cy, sy, cz, sz;
    cx = $cos(ax); sx = $sin(ax);
    cy = $cos(ay); sy = $sin(ay);
    cz = $cos(az); sz = $sin(az);
    m.r00 = q14(cz * cy) + 16'($urandom_range(0, 2 * noise) - noise);
    m.r10 = q14(sz * cy) + 16'($urandom_range(0, 2 * noise) - noise);
    m.r20 = q14(-sy);
    m.r11 = q14(sz * sy * sx + cz * cx);
    m.r12 = q14(sz * sy * cx - cz * sx);
    m.r21 = q14(cy * sx);
    m.r22 = q14(cy * cx);
    return m;
  endfunction

  function automatic real rand_angle();
    return ($urandom_range(0, 200000) / 100000.0 - 1.0) * 3.14159265;
  endfunction

  function automatic rm2e_mat_t random_mat();
    rm2e_mat_t m;
    int sel;
    real ay;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      m = euler_mat(rand_angle(), rand_angle() / 2.0, rand_angle(), 0);
    end else if (sel < 7) begin
      // pitch near +/-90 degrees, around the singular threshold
      ay = ($urandom_range(0, 1) ? 1.0 : -1.0) * 1.5707963 +
           ($urandom_range(0, 2000) / 1000.0 - 1.0) * 0.07;
      m = euler_mat(rand_angle(), ay, rand_angle(), $urandom_range(0, 40));
    end else if (sel < 9) begin
      m = 112'({$urandom(), $urandom(), $urandom(), $urandom()});
    end else begin
      m = 112'({$urandom(), $urandom(), $urandom(), $urandom()});
      m.r00 = 16'($urandom_range(0, 60) - 30);
      m.r10 = 16'($urandom_range(0, 60) - 30);
    end
    return m;
  endfunction

  initial begin
    rm2e_mat_t   m;
    logic [10:0] thr_set [5] = '{11'd0, 11'd1024, 11'd2047, 11'd300, 11'd1};
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    matrix_ch.valid = 1'b0;
    {matrix_ch.r00, matrix_ch.r10, matrix_ch.r11, matrix_ch.r12,
     matrix_ch.r20, matrix_ch.r21, matrix_ch.r22} = '0;
    idle_on = 1'b1;
    long_hold = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: identity, zero, extremes, gimbal lock, negative x axis
    send_mat('{16'sd16384, 0, 16'sd16384, 0, 0, 0, 16'sd16384});
    send_mat('0);
    send_mat({7{16'h7fff}});
    send_mat({7{16'h8000}});
    send_mat('{16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000});
    send_mat('{0, 0, 16'sd16384, 16'sd16384, -16'sd16384, 0, 0});
    send_mat('{0, 0, -16'sd16384, -16'sd16384, 16'sd16384, 0, 0});
    send_mat('{0, 0, 16'sd16384, 0, -16'sd16384, 0, 0});
    send_mat('{-16'sd16384, 0, -16'sd16384, 0, 0, 0, -16'sd16384});
    send_mat('{-16'sd16384, 16'sd5, 0, 0, 0, -16'sd7, -16'sd16384});
    send_mat('{-16'sd16384, -16'sd5, 0, 0, 0, 16'sd7, -16'sd16384});
    send_mat('{16'sd1, 0, 16'sd3, 16'sd9, 16'sd100, 16'sd1, 16'sd1});
    send_mat('{0, 16'sd1, 16'sd20, -16'sd20, 0, -16'sd1, 0});
    send_mat('{16'sd11585, 16'sd11585, 16'sd11585, -16'sd11585, 0, 16'sd11585, 16'sd11585});

    for (int p = 0; p < 5; p++) begin
      set_threshold(thr_set[p]);
      if (p == 4) idle_on = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 40) long_hold = 1'b1;
        m = random_mat();
        send_mat(m);
        if (p == 0 && i < 12) begin
          // boundary sy values for threshold zero
          send_mat('{0, 0, m.r11, m.r12, m.r20, m.r21, m.r22});
        end
      end
    end

    @(negedge clk);
    matrix_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("[rotation_matrix_to_euler_unit] OK");
    end else begin
      $display("[rotation_matrix_to_euler_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ rotation_matrix_to_euler_unit.f @@
+incdir+design
design/rm2e_pkg.sv
design/rm2e_if.sv
design/rm2e_front.sv
design/rm2e_fifo.sv
design/rm2e_cordic.sv
design/rm2e_back.sv
design/rotation_matrix_to_euler_unit.sv
test/rm2e_checker.sv
test/testbench.sv
